FILE: hw/rtl/srpd_pkg.sv
// Shared types and constants for the sensor reply packet deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package srpd_pkg;

  localparam int unsigned PACKET_BUFFER = 128;
  localparam int unsigned HEADER_BYTES  = 9;
  // Largest length that still fits the packet buffer together with the header
  localparam logic [7:0]  LEN_LIMIT     = 8'(PACKET_BUFFER - HEADER_BYTES);
  localparam logic [7:0]  MIN_LENGTH    = 8'd3;

  localparam logic [7:0] SYNC_FIRST  = 8'hEF;
  localparam logic [7:0] SYNC_SECOND = 8'h01;
  localparam logic [7:0] KIND_ACK    = 8'h07;
  localparam logic [7:0] KIND_DATA   = 8'h02;

  localparam logic [6:0] MAX_LENGTH_RESET = 7'd119;

  typedef struct packed {
    logic [7:0]  packet_kind;
    logic [7:0]  body_byte;
    logic [6:0]  body_index;
    logic [6:0]  body_length;
    logic [31:0] module_address;
    logic        last;
  } srpd_result_t;

endpackage

FILE: hw/rtl/sensor_reply_packet_deframer_unit.sv
// Top level of the sensor reply packet deframer.
// Depends on srpd_pkg, srpd_parser and srpd_out_reg.
`timescale 1ns / 1ps

// Usage:
// Received serial bytes enter on in_rx_byte with in_valid/in_stall; a byte is
// taken at a clock edge where in_valid is high and in_stall low. Each payload
// or checksum byte of a valid reply packet leaves on the out_ channel with its
// identifier, index, length, address and a last mark; header, address,
// identifier and length bytes produce nothing.
// The max_length register is written through cfg_valid/cfg_ready with data on
// cfg_max_length (cfg_ready is always high); write it only while idle.
// Throughput: one byte per cycle while no body byte is held back by a full
// result register, set by the single parser state machine that consumes one held byte per clock.
// A body byte taken on the input passes through the input register, then the
// result register, before it is presented on the out_ port.
// When the receiver raises out_stall, the result register holds its
// transaction; the byte behind it waits in the input register, and in_stall
// rises while that held body byte cannot move on. Non-body bytes keep
// flowing during a stall.
// Synchronous active-low reset (rst_n) returns the parser to header hunting,
// empties both registers and sets max_length to 119.

module sensor_reply_packet_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_max_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_packet_kind,
  output logic [7:0]  out_body_byte,
  output logic [6:0]  out_body_index,
  output logic [6:0]  out_body_length,
  output logic [31:0] out_module_address,
  output logic        out_last
);
  import srpd_pkg::*;

  logic         res_valid;
  logic         res_ready;
  srpd_result_t res;
  srpd_result_t out_res;

  srpd_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_max_length (cfg_max_length),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  srpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_packet_kind    = out_res.packet_kind;
  assign out_body_byte      = out_res.body_byte;
  assign out_body_index     = out_res.body_index;
  assign out_body_length    = out_res.body_length;
  assign out_module_address = out_res.module_address;
  assign out_last           = out_res.last;

endmodule

FILE: hw/rtl/srpd_parser.sv
// Input register and packet parsing state machine of the deframer.
// Depends on srpd_pkg; feeds srpd_out_reg with one result per body byte.
`timescale 1ns / 1ps

module srpd_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [6:0]            cfg_max_length,
  output logic                  res_valid,
  input  logic                  res_ready,
  output srpd_pkg::srpd_result_t res
);
  import srpd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_SYNC2, PH_ADDR, PH_KIND, PH_LEN_HI, PH_LEN_LO, PH_BODY
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  header_count_r, header_count_nxt;
  logic [31:0] address_r, address_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic        len_hi_zero_r, len_hi_zero_nxt;
  logic [6:0]  length_r, length_nxt;
  logic [6:0]  body_count_r, body_count_nxt;
  logic [6:0]  max_length_r;
  logic        hold_valid_r;
  logic [7:0]  hold_byte_r;

  logic        take;
  logic        in_accept;
  logic        fin;
  logic [7:0]  len_lo;

  // The held byte moves on unless it is a body byte and the result side is full
  assign take      = hold_valid_r && ((phase_r != PH_BODY) || res_ready);
  assign in_stall  = hold_valid_r && !take;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign fin    = ({1'b0, body_count_r} + 8'd1) >= {1'b0, length_r};
  assign len_lo = hold_byte_r;

  assign res_valid          = hold_valid_r && (phase_r == PH_BODY);
  assign res.packet_kind    = kind_r;
  assign res.body_byte      = hold_byte_r;
  assign res.body_index     = body_count_r;
  assign res.body_length    = length_r;
  assign res.module_address = address_r;
  assign res.last           = fin;

  always_comb begin
    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    address_nxt      = address_r;
    kind_nxt         = kind_r;
    len_hi_zero_nxt  = len_hi_zero_r;
    length_nxt       = length_r;
    body_count_nxt   = body_count_r;
    if (take) begin
      case (phase_r)
        PH_HUNT: begin
          if (hold_byte_r == SYNC_FIRST) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (hold_byte_r == SYNC_SECOND) begin
            phase_nxt        = PH_ADDR;
            header_count_nxt = 2'd0;
            address_nxt      = '0;
          end else if (hold_byte_r != SYNC_FIRST) begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_ADDR: begin
          address_nxt      = {address_r[23:0], hold_byte_r};
          header_count_nxt = header_count_r + 2'd1;
          if (header_count_r == 2'd3) phase_nxt = PH_KIND;
        end
        PH_KIND: begin
          if (hold_byte_r == KIND_ACK || hold_byte_r == KIND_DATA) begin
            kind_nxt  = hold_byte_r;
            phase_nxt = PH_LEN_HI;
          end else if (hold_byte_r == SYNC_FIRST) begin
            phase_nxt = PH_SYNC2;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_LEN_HI: begin
          len_hi_zero_nxt = (hold_byte_r == 8'd0);
          phase_nxt       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          // Nonzero high byte always exceeds the 7-bit limit
          if (len_hi_zero_r && len_lo >= MIN_LENGTH &&
              len_lo <= {1'b0, max_length_r} && len_lo <= LEN_LIMIT) begin
            length_nxt     = len_lo[6:0];
            body_count_nxt = 7'd0;
            phase_nxt      = PH_BODY;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (fin) begin
            body_count_nxt = 7'd0;
            phase_nxt      = PH_HUNT;
          end else begin
            body_count_nxt = body_count_r + 7'd1;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      header_count_r <= 2'd0;
      address_r      <= '0;
      kind_r         <= '0;
      len_hi_zero_r  <= 1'b0;
      length_r       <= '0;
      body_count_r   <= '0;
      max_length_r   <= MAX_LENGTH_RESET;
      hold_valid_r   <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      address_r      <= address_nxt;
      kind_r         <= kind_nxt;
      len_hi_zero_r  <= len_hi_zero_nxt;
      length_r       <= length_nxt;
      body_count_r   <= body_count_nxt;
      if (cfg_valid && cfg_ready) max_length_r <= cfg_max_length;
      if (in_accept) begin
        hold_valid_r <= 1'b1;
      end else if (take) begin
        hold_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) hold_byte_r <= in_rx_byte;
  end

endmodule

FILE: hw/rtl/srpd_out_reg.sv
// Result register of the deframer: holds one result until the receiver takes it.
// Depends on srpd_pkg for the result struct.
`timescale 1ns / 1ps

module srpd_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_valid,
  output logic                  res_ready,
  input  srpd_pkg::srpd_result_t res,
  output logic                  out_valid,
  input  logic                  out_stall,
  output srpd_pkg::srpd_result_t out_res
);
  import srpd_pkg::*;

  logic         valid_r;
  srpd_result_t data_r;

  // Free when empty or when the held result leaves this cycle
  assign res_ready = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) data_r <= res;
  end

endmodule

FILE: dv/sensor_reply_packet_deframer_unit_test.sv
// Self-checking testbench for sensor_reply_packet_deframer_unit: framed and noisy byte
// traffic under several max_length settings, checked against an in-bench packet parser.
// Depends on srpd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module sensor_reply_packet_deframer_unit_test;
  import srpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef enum logic [2:0] {
    ST_HUNT, ST_SYNC2, ST_ADDR, ST_KIND, ST_LEN_HI, ST_LEN_LO, ST_BODY
  } parse_state_t;

  class deframer_scoreboard;
    logic [6:0]   max_len;
    parse_state_t state;
    logic [1:0]   addr_cnt;
    logic [31:0]  addr;
    logic [7:0]   kind;
    logic [15:0]  len;
    logic [6:0]   idx;
    srpd_result_t expected_q[$];
    int unsigned  errors;
    int unsigned  checked;

    function new();
      max_len  = MAX_LENGTH_RESET;
      state    = ST_HUNT;
      addr_cnt = '0;
      addr     = '0;
      kind     = '0;
      len      = '0;
      idx      = '0;
      errors   = 0;
      checked  = 0;
    endfunction

    // Advance the parser by one accepted byte; queue a result for body bytes.
    function void note_input(logic [7:0] b);
      srpd_result_t r;
      logic fin;
      case (state)
        ST_HUNT: if (b == SYNC_FIRST) state = ST_SYNC2;
        ST_SYNC2: begin
          if (b == SYNC_SECOND) begin
            state    = ST_ADDR;
            addr_cnt = '0;
            addr     = '0;
          end else if (b != SYNC_FIRST) begin
            state = ST_HUNT;
          end
        end
        ST_ADDR: begin
          addr = {addr[23:0], b};
          if (addr_cnt == 2'd3) begin
            addr_cnt = '0;
            state    = ST_KIND;
          end else begin
            addr_cnt++;
          end
        end
        ST_KIND: begin
          if (b == KIND_ACK || b == KIND_DATA) begin
            kind  = b;
            state = ST_LEN_HI;
          end else begin
            // a bad identifier equal to the first sync byte reopens a header
            state = (b == SYNC_FIRST) ? ST_SYNC2 : ST_HUNT;
          end
        end
        ST_LEN_HI: begin
          len   = {b, 8'h00};
          state = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          len = {len[15:8], b};
          if (len >= 16'(MIN_LENGTH) && len <= {9'd0, max_len} &&
              (32'(len) + HEADER_BYTES) <= PACKET_BUFFER) begin
            idx   = '0;
            state = ST_BODY;
          end else begin
            state = ST_HUNT;
          end
        end
        ST_BODY: begin
          fin = (({9'd0, idx} + 16'd1) >= len);
          r.packet_kind    = kind;
          r.body_byte      = b;
          r.body_index     = idx;
          r.body_length    = len[6:0];
          r.module_address = addr;
          r.last           = fin;
          expected_q.push_back(r);
          if (fin) begin
            idx   = '0;
            state = ST_HUNT;
          end else begin
            idx++;
          end
        end
        default: state = ST_HUNT;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      end
    endfunction

    function void check_result(srpd_result_t got);
      srpd_result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual byte %h index %0d",
                 $time, got.body_byte, got.body_index);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      compare_field("packet_kind", 32'(exp.packet_kind), 32'(got.packet_kind));
      compare_field("body_byte", 32'(exp.body_byte), 32'(got.body_byte));
      compare_field("body_index", 32'(exp.body_index), 32'(got.body_index));
      compare_field("body_length", 32'(exp.body_length), 32'(got.body_length));
      compare_field("module_address", exp.module_address, got.module_address);
      compare_field("last", 32'(exp.last), 32'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_max_length;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_packet_kind;
  logic [7:0]  out_body_byte;
  logic [6:0]  out_body_index;
  logic [6:0]  out_body_length;
  logic [31:0] out_module_address;
  logic        out_last;

  deframer_scoreboard sb = new();
  logic [7:0]  frame_q[$];
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned bytes_sent;
  int unsigned settings_used;
  int unsigned cycle_count;

  sensor_reply_packet_deframer_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_length     (cfg_max_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_packet_kind    (out_packet_kind),
    .out_body_byte      (out_body_byte),
    .out_body_index     (out_body_index),
    .out_body_length    (out_body_length),
    .out_module_address (out_module_address),
    .out_last           (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // input transactions feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_rx_byte);
  end

  // result transactions are checked; receiver stalls at the current rate
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_packet_kind, out_body_byte, out_body_index, out_body_length,
                       out_module_address, out_last});
    end
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i]);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender holds off until every pending result is out, then the pipe settles
  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [6:0] v);
    cfg_valid      <= 1'b1;
    cfg_max_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.max_len = v;
    settings_used++;
  endtask

  function automatic logic [31:0] pick_address();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Build one reply frame; rejected frames get zero to three stray bytes instead of a body.
  function automatic void build_frame(input logic [7:0] kind, input logic [15:0] len,
                                      input logic [31:0] addr, input bit broken);
    bit accepted;
    int unsigned n;
    int unsigned keep;
    accepted = (len >= 16'(MIN_LENGTH)) && (len <= {9'd0, sb.max_len}) && (len <= 16'd119) &&
               (kind == KIND_ACK || kind == KIND_DATA);
    frame_q.delete();
    frame_q.push_back(SYNC_FIRST);
    frame_q.push_back(SYNC_SECOND);
    for (int i = 3; i >= 0; i--) frame_q.push_back(addr[8*i +: 8]);
    frame_q.push_back(kind);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
    n = accepted ? int'(len) : $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      // sync bytes inside the body are plain data
      frame_q.push_back(($urandom_range(0, 9) == 0) ? SYNC_FIRST : 8'($urandom));
    end
    if (broken) begin
      keep = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    end
  endfunction

  task automatic run_setting(input logic [6:0] setting, input int unsigned budget);
    int unsigned start;
    int unsigned r;
    logic [7:0]  kind;
    logic [15:0] len;
    wait_drained();
    write_max_length(setting);
    // boundary lengths: the limit itself, then one past the limit
    build_frame(KIND_ACK, (setting > 7'd119) ? 16'd119 : 16'(setting), pick_address(), 1'b0);
    send_frame();
    build_frame(KIND_DATA, (setting > 7'd119) ? 16'd120 : 16'(setting) + 16'd1,
                pick_address(), 1'b0);
    send_frame();
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      if ($urandom_range(0, 99) < 30) begin
        frame_q.delete();
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
        send_frame();
      end
      r = $urandom_range(0, 99);
      kind = (r < 45) ? KIND_ACK : (r < 90) ? KIND_DATA : 8'($urandom);
      r = $urandom_range(0, 99);
      if (r < 70) len = 16'($urandom_range(3, 16));
      else if (r < 82) len = 16'($urandom_range(3, 127));
      else if (r < 90) len = 16'($urandom_range(0, 2));
      else len = {8'($urandom_range(1, 255)), 8'($urandom)};
      build_frame(kind, len, pick_address(), $urandom_range(0, 99) < 6);
      send_frame();
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_rx_byte     <= '0;
    cfg_valid      <= 1'b0;
    cfg_max_length <= '0;
    out_stall      <= 1'b0;
    in_idle_pct    = 7;
    out_idle_pct   = 82;
    bytes_sent     = 0;
    settings_used  = 0;
    cycle_count    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait_drained();
    write_max_length(7'd119);
    // wrong second sync byte, repeated first sync byte, zero address, body with sync byte
    frame_q = '{SYNC_FIRST, 8'h55, SYNC_FIRST, SYNC_FIRST, SYNC_SECOND,
                8'h00, 8'h00, 8'h00, 8'h00, KIND_DATA, 8'h00, 8'h03,
                SYNC_FIRST, 8'hFF, 8'h00};
    send_frame();
    // bad identifier that reopens a header, then a too-short length
    frame_q = '{SYNC_FIRST, SYNC_SECOND, 8'hFF, 8'hFF, 8'hFF, 8'hFF, SYNC_FIRST,
                SYNC_SECOND, 8'hA5, 8'h5A, 8'hC3, 8'h3C, KIND_ACK, 8'h00, 8'h02};
    send_frame();

    run_setting(7'd119, 120);
    run_setting(7'd3, 70);

    in_idle_pct  = 82;
    out_idle_pct = 7;
    run_setting(7'd2, 40);      // nothing can be accepted
    run_setting(7'd127, 120);   // packet buffer becomes the limit

    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_setting(7'd77, 100);
    run_setting(7'($urandom_range(3, 119)), 100);

    wait_drained();
    $display("Covered %0d input bytes and %0d checked body bytes over %0d max_length settings",
             bytes_sent, sb.checked, settings_used);
    $display("Errors: %0d, results still pending: %0d", sb.errors, sb.expected_q.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
